// ----- sv/parallel_port_interface_core_assert.svh -----
// Assertion helpers shared by the block; clocked on clock, quiet during reset.
`ifndef PARALLEL_PORT_INTERFACE_CORE_ASSERT_SVH
`define PARALLEL_PORT_INTERFACE_CORE_ASSERT_SVH

// same-cycle implication
`define PPI_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("ppi assertion failed");

// next-cycle implication
`define PPI_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("ppi assertion failed");

`endif

// ----- sv/ppi_pkg.sv -----
package ppi_pkg;

   localparam logic [6:0] MODE_RESET = 7'h1b;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_PIN   = 2'd2;

   localparam logic [1:0] OFF_PORT_A = 2'd0;
   localparam logic [1:0] OFF_PORT_B = 2'd1;
   localparam logic [1:0] OFF_PORT_C = 2'd2;
   localparam logic [1:0] OFF_CTRL   = 2'd3;

   localparam logic [1:0] MODE_A_PLAIN   = 2'd0;
   localparam logic [1:0] MODE_A_STROBED = 2'd1;
   localparam logic [1:0] MODE_A_BIDIR   = 2'd2;

   localparam int ACK_A_BIT = 6;
   localparam int ACK_B_BIT = 2;

   localparam logic [7:0] RSV_MODE_A_STROBED = 8'h38;
   localparam logic [7:0] RSV_MODE_A_BIDIR   = 8'hF8;
   localparam logic [7:0] RSV_MODE_B_STROBED = 8'h07;
   localparam logic [7:0] CTRL_READ_VALUE    = 8'hFF;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] reg_offset;
      logic [7:0] wr_byte;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
      logic [7:0] port_c_pins;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
      logic [7:0] port_c_out;
      logic [2:0] port_write_strobes;
   } result_type;

   function automatic logic [1:0] mode_a(input logic [6:0] m);
      mode_a = (m[6:5] == 2'd3) ? MODE_A_BIDIR : m[6:5];
   endfunction

   function automatic logic [7:0] clear_reserved(input logic [7:0] v, input logic [6:0] m);
      logic [7:0] r;
      r = v;
      if (mode_a(m) == MODE_A_STROBED) r = r & ~RSV_MODE_A_STROBED;
      if (mode_a(m) == MODE_A_BIDIR)   r = r & ~RSV_MODE_A_BIDIR;
      if (m[2])                        r = r & ~RSV_MODE_B_STROBED;
      return r;
   endfunction

   function automatic logic [7:0] in_mask(input logic [1:0] p, input logic [6:0] m);
      logic [7:0] r;
      case (p)
         OFF_PORT_A: r = {8{m[4]}};
         OFF_PORT_B: r = {8{m[1]}};
         default:    r = clear_reserved({{4{m[3]}}, {4{m[0]}}}, m);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] drv_mask(input logic [1:0] p, input logic [6:0] m);
      logic [7:0] r;
      case (p)
         OFF_PORT_A: r = {8{~m[4]}};
         OFF_PORT_B: r = {8{~m[1]}};
         default:    r = clear_reserved({{4{~m[3]}}, {4{~m[0]}}}, m);
      endcase
      return r;
   endfunction

   // substitute OBF/INTE/IBF bits of port C; INTE and IBF read as 0
   function automatic logic [7:0] with_handshake(input logic [7:0] v, input logic [6:0] m,
                                                 input logic fa, input logic fb);
      logic [7:0] hs;
      logic [7:0] mask;
      hs   = 8'h00;
      mask = 8'h00;
      if (mode_a(m) == MODE_A_STROBED) begin
         if (m[4]) begin
            mask = mask | 8'h28;
         end else begin
            hs[7] = ~fa;
            mask  = mask | 8'h88;
         end
      end else if (mode_a(m) == MODE_A_BIDIR) begin
         hs[7] = ~fa;
         mask  = mask | 8'hA8;
      end
      if (m[2]) begin
         hs[1] = ~m[1] & ~fb;
         mask  = mask | 8'h03;
      end
      return (v & ~mask) | (hs & mask);
   endfunction

   function automatic logic [7:0] drive_value(input logic [1:0] p, input logic [6:0] m,
                                              input logic [7:0] latch,
                                              input logic fa, input logic fb);
      logic [7:0] om;
      logic [7:0] v;
      om = drv_mask(p, m);
      v  = (latch & om) | ~om;
      if (p == OFF_PORT_C) v = with_handshake(v, m, fa, fb);
      return v;
   endfunction

endpackage

// ----- sv/ppi_channels.sv -----
interface ppi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [1:0] reg_offset;
   logic [7:0] wr_byte;
   logic [7:0] port_a_pins;
   logic [7:0] port_b_pins;
   logic [7:0] port_c_pins;

   modport source (output valid, opcode, reg_offset, wr_byte,
                   port_a_pins, port_b_pins, port_c_pins, input ready);
   modport sink   (input valid, opcode, reg_offset, wr_byte,
                   port_a_pins, port_b_pins, port_c_pins, output ready);
endinterface

interface ppi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] port_a_out;
   logic [7:0] port_b_out;
   logic [7:0] port_c_out;
   logic [2:0] port_write_strobes;

   modport source (output valid, read_data, port_a_out, port_b_out, port_c_out,
                   port_write_strobes, input ready);
   modport sink   (input valid, read_data, port_a_out, port_b_out, port_c_out,
                   port_write_strobes, output ready);
endinterface

// ----- sv/parallel_port_interface_core.sv -----
// Three-port parallel peripheral core.
// req_chan carries one beat per bus read, bus write or port C pin event,
// together with the current levels on the three port pin groups.
// rsp_chan returns one beat per request: the read byte (zero unless a read),
// the driven values of ports A, B and C after the request, and a strobe per
// port whose output was refreshed by it.
// A beat taken into the request register passes the update stage into the
// response register and rsp_chan. Throughput: one beat per cycle while rsp_chan
// does not stall, set by the single update stage between the two registers.
// When rsp_chan stalls the finished beat waits in the response register while
// one further request is still taken into the request register; req_chan.ready
// drops only once both are full.
// Reset (synchronous, active high) empties both registers and returns the
// mode to all ports input with modes zero, clearing latches, drives and OBF.
`include "parallel_port_interface_core_assert.svh"

module parallel_port_interface_core import ppi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ppi_req_if.sink      req_chan,
   ppi_rsp_if.source    rsp_chan
);

   item_type   item_ff, item_in;
   logic       in_valid_ff;
   result_type result_ff, result_in;
   logic       out_valid_ff;
   logic       advance;
   logic       take;
   logic       mode_beat;
   logic       read_beat;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   assign item_in.opcode      = req_chan.opcode;
   assign item_in.reg_offset  = req_chan.reg_offset;
   assign item_in.wr_byte     = req_chan.wr_byte;
   assign item_in.port_a_pins = req_chan.port_a_pins;
   assign item_in.port_b_pins = req_chan.port_b_pins;
   assign item_in.port_c_pins = req_chan.port_c_pins;

   ppi_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) item_ff <= item_in;
      if (advance) result_ff <= result_in;
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.read_data          = result_ff.read_data;
   assign rsp_chan.port_a_out         = result_ff.port_a_out;
   assign rsp_chan.port_b_out         = result_ff.port_b_out;
   assign rsp_chan.port_c_out         = result_ff.port_c_out;
   assign rsp_chan.port_write_strobes = result_ff.port_write_strobes;

   assign mode_beat = advance && item_ff.opcode == OP_WRITE &&
                      item_ff.reg_offset == OFF_CTRL && item_ff.wr_byte[7];
   assign read_beat = out_valid_ff && result_ff.read_data != 8'h00;

   // a held request must not be lost while the response side stalls
   `PPI_ASSERT_NEXT(a_hold_request, in_valid_ff && !advance, in_valid_ff)
   // a mode word refreshes all three ports
   `PPI_ASSERT_NEXT(a_mode_refresh, mode_beat, result_ff.port_write_strobes == 3'b111)
   // reads never refresh ports A or B
   `PPI_ASSERT_NOW(a_read_no_ab_strobe, read_beat, result_ff.port_write_strobes[1:0] == 2'b00)

endmodule

// ----- sv/ppi_exec.sv -----
module ppi_exec import ppi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic [6:0] mode_ff, mode_in;
   logic [7:0] latch_ff [3];
   logic [7:0] latch_in [3];
   logic [7:0] drive_ff [3];
   logic [7:0] drive_in [3];
   logic       obf_a_ff, obf_a_in;
   logic       obf_b_ff, obf_b_in;
   logic [2:0] strobes;
   logic [7:0] rd;
   logic       pin_event;
   logic [7:0] im;
   logic [7:0] pins_sel;
   logic [7:0] latch_sel;
   logic [7:0] raw;

   always_comb begin
      mode_in   = mode_ff;
      latch_in  = latch_ff;
      obf_a_in  = obf_a_ff;
      obf_b_in  = obf_b_ff;
      strobes   = 3'b000;
      rd        = 8'h00;
      pin_event = 1'b0;
      im        = in_mask(item.reg_offset, mode_ff);

      case (item.reg_offset)
         OFF_PORT_A: begin
            pins_sel  = item.port_a_pins;
            latch_sel = latch_ff[0];
         end
         OFF_PORT_B: begin
            pins_sel  = item.port_b_pins;
            latch_sel = latch_ff[1];
         end
         default: begin
            pins_sel  = item.port_c_pins;
            latch_sel = latch_ff[2];
         end
      endcase

      case (item.opcode)
         OP_READ: begin
            if (item.reg_offset == OFF_CTRL) begin
               rd = CTRL_READ_VALUE;
            end else if (item.reg_offset == OFF_PORT_C && im != 8'h00) begin
               pin_event = 1'b1;
            end
         end
         OP_WRITE: begin
            if (item.reg_offset != OFF_CTRL) begin
               latch_in[item.reg_offset] = item.wr_byte;
               strobes[item.reg_offset]  = 1'b1;
               if (item.reg_offset == OFF_PORT_A && !mode_ff[4] &&
                   mode_a(mode_ff) != MODE_A_PLAIN) begin
                  obf_a_in   = 1'b1;
                  strobes[2] = 1'b1;
               end else if (item.reg_offset == OFF_PORT_B && !mode_ff[1] && mode_ff[2]) begin
                  obf_b_in   = 1'b1;
                  strobes[2] = 1'b1;
               end
            end else if (item.wr_byte[7]) begin
               mode_in  = item.wr_byte[6:0];
               latch_in = '{default: 8'h00};
               strobes  = 3'b111;
            end else begin
               latch_in[2][item.wr_byte[3:1]] = item.wr_byte[0];
               strobes[2] = 1'b1;
            end
         end
         OP_PIN:  pin_event = 1'b1;
         default: ;
      endcase

      // ACK low drops OBF for an output handshake group
      if (pin_event) begin
         if (((mode_a(mode_ff) == MODE_A_STROBED && !mode_ff[4]) ||
              mode_a(mode_ff) == MODE_A_BIDIR) && obf_a_ff && !item.port_c_pins[ACK_A_BIT]) begin
            obf_a_in   = 1'b0;
            strobes[2] = 1'b1;
         end
         if (mode_ff[2] && !mode_ff[1] && obf_b_ff && !item.port_c_pins[ACK_B_BIT]) begin
            obf_b_in   = 1'b0;
            strobes[2] = 1'b1;
         end
      end

      raw = (pins_sel & im) | (latch_sel & drv_mask(item.reg_offset, mode_ff));
      if (item.opcode == OP_READ && item.reg_offset != OFF_CTRL) begin
         rd = (item.reg_offset == OFF_PORT_C) ?
              with_handshake(raw, mode_ff, obf_a_in, obf_b_in) : raw;
      end

      for (int p = 0; p < 3; p++) begin
         drive_in[p] = strobes[p] ?
                       drive_value(2'(p), mode_in, latch_in[p], obf_a_in, obf_b_in) :
                       drive_ff[p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         latch_ff <= '{default: 8'h00};
         drive_ff <= '{default: 8'h00};
         obf_a_ff <= 1'b0;
         obf_b_ff <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         latch_ff <= latch_in;
         drive_ff <= drive_in;
         obf_a_ff <= obf_a_in;
         obf_b_ff <= obf_b_in;
      end
   end

   assign result.read_data          = rd;
   assign result.port_a_out         = drive_in[0];
   assign result.port_b_out         = drive_in[1];
   assign result.port_c_out         = drive_in[2];
   assign result.port_write_strobes = strobes;

endmodule
